### hw/rtl/wav_header_chunk_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_unit_macros
// Assertion helpers for the WAV header parser.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_CHUNK_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_CHUNK_PARSER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAVHP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never be true outside reset.
`define WAVHP_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### hw/rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

  // One byte of the file stream with its framing flags.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  // One parse result.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } result_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_MARKS = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_NO_DATA   = 3'd4;

  localparam logic [5:0] HEADER_LAST = 6'd35;

  // Marks as little-endian words: byte 0 in bits 7:0.
  localparam logic [31:0] RIFF_MARK = 32'h4646_4952;
  localparam logic [31:0] WAVE_MARK = 32'h4556_4157;
  localparam logic [31:0] DATA_TAG  = 32'h6174_6164;

  localparam int FQ_DEPTH = 2;
  localparam int RQ_DEPTH = 2;

endpackage

`default_nettype wire

### hw/rtl/wavhp_front.sv
// ----------------------------------------------------------------------------
// wavhp_front
// Input side: accepts stream bytes and holds them in a short queue for the
// parser back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  wire  [7:0]          data_byte,
  input  wire                 first_byte,
  input  wire                 last_byte,
  output logic                out_valid,
  output wavhp_pkg::item_t    out_item,
  input  wire                 out_ready
);
  import wavhp_pkg::*;

  localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(FQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FQ_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(FQ_DEPTH - 1);

  item_t            slots [FQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             wr_en;
  logic             rd_en;
  item_t            in_item;

  assign in_item.data  = data_byte;
  assign in_item.first = first_byte;
  assign in_item.last  = last_byte;

  assign full      = (count == DEPTH_C);
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wavhp_parser.sv
// ----------------------------------------------------------------------------
// wavhp_parser
// Back end: walks the header and the chunk list one byte per cycle while the
// result queue has room, and produces at most one result per file.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_parser (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wavhp_pkg::item_t    in_item,
  output logic                in_ready,
  output logic                res_valid,
  output wavhp_pkg::result_t  res,
  input  wire                 res_ready
);
  import wavhp_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_CHUNK  = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  logic [1:0]  phase,    phase_next;
  logic [5:0]  hpos,     hpos_next;
  logic        marks_good, marks_good_next;
  logic [2:0]  cpos,     cpos_next;
  logic [15:0] sv_format, sv_format_next;
  logic [15:0] sv_chan,   sv_chan_next;
  logic [31:0] sv_rate,   sv_rate_next;
  logic [31:0] sv_brate,  sv_brate_next;
  logic [15:0] sv_align,  sv_align_next;
  logic [15:0] sv_bits,   sv_bits_next;
  logic [31:0] tag,       tag_next;
  logic [31:0] size,      size_next;
  logic [31:0] skip,      skip_next;

  logic        fire;
  logic [1:0]  eff_phase;
  logic [5:0]  eff_hpos;
  logic        eff_marks;
  logic [7:0]  b;
  logic        emit;
  logic [2:0]  emit_status;
  logic [31:0] size_full;
  logic [31:0] skip_dec;
  logic [7:0]  expect_byte;
  logic        is_mark;

  assign in_ready = res_ready;
  assign fire     = in_valid && in_ready;
  assign b        = in_item.data;

  // A first byte restarts the parse at header byte zero.
  assign eff_phase = in_item.first ? PH_HEADER : phase;
  assign eff_hpos  = in_item.first ? 6'd0 : hpos;
  assign eff_marks = in_item.first ? 1'b1 : marks_good;

  assign size_full = {b, size[23:0]};
  assign skip_dec  = skip - 32'd1;

  always_comb begin
    is_mark     = 1'b0;
    expect_byte = 8'd0;
    if (eff_hpos < 6'd4) begin
      is_mark     = 1'b1;
      expect_byte = RIFF_MARK[{eff_hpos[1:0], 3'b000} +: 8];
    end else if (eff_hpos >= 6'd8 && eff_hpos < 6'd12) begin
      is_mark     = 1'b1;
      expect_byte = WAVE_MARK[{eff_hpos[1:0], 3'b000} +: 8];
    end
  end

  always_comb begin
    phase_next      = phase;
    hpos_next       = hpos;
    marks_good_next = marks_good;
    cpos_next       = cpos;
    sv_format_next  = sv_format;
    sv_chan_next    = sv_chan;
    sv_rate_next    = sv_rate;
    sv_brate_next   = sv_brate;
    sv_align_next   = sv_align;
    sv_bits_next    = sv_bits;
    tag_next        = tag;
    size_next       = size;
    skip_next       = skip;
    emit            = 1'b0;
    emit_status     = ST_OK;

    if (fire) begin
      unique case (eff_phase)
        PH_HEADER: begin
          marks_good_next = eff_marks && !(is_mark && (b != expect_byte));
          if (eff_hpos >= 6'd20 && eff_hpos < 6'd22) begin
            sv_format_next[{eff_hpos[0], 3'b000} +: 8] = b;
          end else if (eff_hpos >= 6'd22 && eff_hpos < 6'd24) begin
            sv_chan_next[{eff_hpos[0], 3'b000} +: 8] = b;
          end else if (eff_hpos >= 6'd24 && eff_hpos < 6'd28) begin
            sv_rate_next[{eff_hpos[1:0], 3'b000} +: 8] = b;
          end else if (eff_hpos >= 6'd28 && eff_hpos < 6'd32) begin
            sv_brate_next[{eff_hpos[1:0], 3'b000} +: 8] = b;
          end else if (eff_hpos >= 6'd32 && eff_hpos < 6'd34) begin
            sv_align_next[{eff_hpos[0], 3'b000} +: 8] = b;
          end else if (eff_hpos >= 6'd34) begin
            sv_bits_next[{eff_hpos[0], 3'b000} +: 8] = b;
          end
          phase_next = PH_HEADER;
          if (eff_hpos >= HEADER_LAST) begin
            hpos_next = 6'd0;
            if (!marks_good_next) begin
              emit        = 1'b1;
              emit_status = ST_BAD_MARKS;
            end else if (in_item.last) begin
              emit        = 1'b1;
              emit_status = ST_NO_DATA;
            end else begin
              phase_next = PH_CHUNK;
              cpos_next  = 3'd0;
            end
          end else begin
            hpos_next = eff_hpos + 6'd1;
            if (in_item.last) begin
              emit        = 1'b1;
              emit_status = ST_SHORT;
            end
          end
        end
        PH_CHUNK: begin
          if (!cpos[2]) begin
            tag_next[{cpos[1:0], 3'b000} +: 8] = b;
          end else begin
            size_next[{cpos[1:0], 3'b000} +: 8] = b;
          end
          if (cpos == 3'd7) begin
            if (tag == DATA_TAG) begin
              emit        = 1'b1;
              emit_status = (size_full == 32'd0) ? ST_NO_DATA : ST_OK;
            end else if (in_item.last) begin
              emit        = 1'b1;
              emit_status = ST_NO_DATA;
            end else begin
              skip_next  = size_full;
              cpos_next  = 3'd0;
              phase_next = (size_full != 32'd0) ? PH_SKIP : PH_CHUNK;
            end
          end else begin
            cpos_next = cpos + 3'd1;
            if (in_item.last) begin
              emit        = 1'b1;
              emit_status = (cpos < 3'd3) ? ST_NO_DATA : ST_TRUNC;
            end
          end
        end
        PH_SKIP: begin
          skip_next = skip_dec;
          if (in_item.last) begin
            emit        = 1'b1;
            emit_status = ST_NO_DATA;
          end else if (skip_dec == 32'd0) begin
            phase_next = PH_CHUNK;
            cpos_next  = 3'd0;
          end
        end
        PH_IDLE: begin
          // drop bytes outside a file
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      if (emit) begin
        phase_next = PH_IDLE;
        cpos_next  = 3'd0;
      end
    end
  end

  // Zero every field but status on a failed parse.
  always_comb begin
    res.status        = emit_status;
    res.audio_format  = '0;
    res.channel_count = '0;
    res.sample_rate   = '0;
    res.byte_rate     = '0;
    res.frame_bytes   = '0;
    res.sample_bits   = '0;
    res.data_length   = '0;
    if (emit_status == ST_OK) begin
      res.audio_format  = sv_format;
      res.channel_count = sv_chan;
      res.sample_rate   = sv_rate;
      res.byte_rate     = sv_brate;
      res.frame_bytes   = sv_align;
      res.sample_bits   = sv_bits;
      res.data_length   = size_full;
    end
  end

  assign res_valid = fire && emit;

  always_ff @(posedge clk) begin
    sv_format <= sv_format_next;
    sv_chan   <= sv_chan_next;
    sv_rate   <= sv_rate_next;
    sv_brate  <= sv_brate_next;
    sv_align  <= sv_align_next;
    sv_bits   <= sv_bits_next;
    tag       <= tag_next;
    size      <= size_next;
    skip      <= skip_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hpos       <= 6'd0;
      marks_good <= 1'b1;
      cpos       <= 3'd0;
    end else begin
      phase      <= phase_next;
      hpos       <= hpos_next;
      marks_good <= marks_good_next;
      cpos       <= cpos_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wavhp_result_q.sv
// ----------------------------------------------------------------------------
// wavhp_result_q
// Output side: a short queue of finished results, popped by the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_result_q (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 wr_valid,
  input  wavhp_pkg::result_t  wr_data,
  output logic                wr_ready,
  output logic                empty,
  input  wire                 pop,
  output wavhp_pkg::result_t  rd_data
);
  import wavhp_pkg::*;

  localparam int PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RQ_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(RQ_DEPTH - 1);

  result_t          slots [RQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             wr_en;
  logic             rd_en;

  assign wr_ready = (count != DEPTH_C);
  assign empty    = (count == '0);
  assign rd_data  = slots[rd_ptr];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = pop && !empty;

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wav_header_chunk_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_unit
// WAV header parser: captures the fixed header, checks its marks, walks the
// chunk list to the data chunk and reports format fields and data length.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  bytes     in         push / full        data_byte, first_byte, last_byte
//  results   out        empty / pop        status, audio_format, channel_count,
//                                          sample_rate, byte_rate, frame_bytes,
//                                          sample_bits, data_length
//
//  One byte per cycle sustained while the result queue is not full; the parser
//  back end handles one byte a cycle. Each byte passes through the byte queue,
//  and a result is registered in the result queue when the parser takes the byte that ends the parse.
//  Synchronous reset empties both queues and returns the parser to idle.
//  A full result queue stalls the parser; the two-entry byte queue then fills
//  and raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_chunk_parser_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  data_byte,
  input  wire         first_byte,
  input  wire         last_byte,
  output logic        empty,
  input  wire         pop,
  output logic [2:0]  status,
  output logic [15:0] audio_format,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [31:0] byte_rate,
  output logic [15:0] frame_bytes,
  output logic [15:0] sample_bits,
  output logic [31:0] data_length
);
  import wavhp_pkg::*;

`include "wav_header_chunk_parser_unit_macros.svh"

  logic    byte_valid;
  item_t   byte_item;
  logic    byte_ready;
  logic    res_valid;
  result_t res;
  logic    res_ready;
  result_t head;

  wavhp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .out_valid  (byte_valid),
    .out_item   (byte_item),
    .out_ready  (byte_ready)
  );

  wavhp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_valid),
    .in_item   (byte_item),
    .in_ready  (byte_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  wavhp_result_q u_result_q (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_data  (res),
    .wr_ready (res_ready),
    .empty    (empty),
    .pop      (pop),
    .rd_data  (head)
  );

  assign status        = head.status;
  assign audio_format  = head.audio_format;
  assign channel_count = head.channel_count;
  assign sample_rate   = head.sample_rate;
  assign byte_rate     = head.byte_rate;
  assign frame_bytes   = head.frame_bytes;
  assign sample_bits   = head.sample_bits;
  assign data_length   = head.data_length;

  `WAVHP_ASSERT_NEVER(a_no_result_lost, clk, rst, res_valid && !res_ready, "result dropped")
  `WAVHP_ASSERT_IMPL(a_fail_fields_zero, clk, rst, !empty && (status != ST_OK), (audio_format == 16'd0) && (sample_rate == 32'd0) && (data_length == 32'd0), "failed result has fields")
  `WAVHP_ASSERT_IMPL(a_reset_clean, clk, rst, $fell(rst), empty && !full, "queues not clear after reset")

endmodule

`default_nettype wire
